// File: src/lruc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lruc_pkg;

    // Default geometry
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths and reset capacity
    localparam int CFG_BITS  = 5;
    localparam int OCC_BITS  = 5;
    localparam int CAP_RESET = 16;

    // Operation codes
    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } t_func;

    // Per-cycle control broadcast to every entry
    typedef struct packed {
        logic fire;    // an operation completes this cycle
        logic hit;     // the key matched a valid entry
        logic put;     // the operation is a put
    } t_entry_ctl;

endpackage

`default_nettype wire

// File: src/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each request word (get or put) is registered, then compared against all
// entries at once. The hit, value read, eviction choice and rank update are
// resolved combinationally and land in the result register. A word can be
// taken every cycle while the result side keeps up. Its result is
// registered when the word fires. A stalled result holds the next word in
// the input register. The parallel key compare and rank update across all
// ENTRIES entries set the cycle time. Write the capacity register only while
// idle. A write of 0 counts as 1, and a value above ENTRIES counts as ENTRIES.
// Lowering the capacity below the occupancy does not shrink the cache: each
// later new-key put evicts one entry and inserts one. No clearing pass runs
// after reset.
module lru_key_value_cache_unit #(
    parameter int ENTRIES    = lruc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lruc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lruc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lruc_pkg::CFG_BITS-1:0] i_cfg_data,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [KEY_BITS-1:0]           i_lookup_key,
    input  logic [VALUE_BITS-1:0]         i_write_value,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [VALUE_BITS-1:0]         o_read_value,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key,
    output logic [lruc_pkg::OCC_BITS-1:0] o_occupancy
);
    import lruc_pkg::*;

    localparam int RankW    = $clog2(ENTRIES);
    localparam int CntW     = $clog2(ENTRIES + 1);
    localparam int OccW     = (CntW > OCC_BITS) ? CntW : OCC_BITS;
    localparam int CmpW     = (CntW > CFG_BITS) ? CntW : CFG_BITS;
    localparam int CapReset = (ENTRIES < CAP_RESET) ? ENTRIES : CAP_RESET;

    // Configuration and counters
    logic [CntW-1:0]       r_cap, n_cap;
    logic [CntW-1:0]       r_count, n_count;

    // Input register
    logic                  r_in_valid;
    t_func                 r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;

    // Result register
    logic                  r_out_valid;
    logic                  r_hit, n_hit;
    logic [VALUE_BITS-1:0] r_rdval, n_rdval;
    logic                  r_ev, n_ev;
    logic [KEY_BITS-1:0]   r_evk, n_evk;
    logic [OCC_BITS-1:0]   r_occ, n_occ;

    // Entry array signals
    logic [ENTRIES-1:0]    w_valid, w_match, w_lru, w_free_oh, w_sel;
    logic [RankW-1:0]      w_rank  [ENTRIES];
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [VALUE_BITS-1:0] w_value [ENTRIES];
    logic [RankW-1:0]      w_found_rank;
    logic [RankW-1:0]      w_lru_rank;
    logic [VALUE_BITS-1:0] w_hit_value;
    logic                  w_is_put;
    logic                  w_evict;
    logic                  w_fire;
    logic [OccW-1:0]       w_occ_ext;
    t_entry_ctl            w_ctl;

    // Handshakes: process when the result slot is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign o_cfg_ready = 1'b1;

    assign w_is_put = (r_func == FUNC_PUT);

    // Entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
        lruc_entry #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .RANK_BITS  (RankW)
        ) u_entry (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_sel        (w_sel[g]),
            .i_key        (r_key),
            .i_value      (r_wval),
            .i_found_rank (w_found_rank),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_rank       (w_rank[g]),
            .o_key        (w_key[g]),
            .o_value      (w_value[g])
        );
    end

    // Least recent valid entry holds rank count-1
    assign w_lru_rank = RankW'(r_count - CntW'(1));

    // Gather hit data, LRU victim and victim key across entries
    always_comb begin
        w_found_rank = '0;
        w_hit_value  = '0;
        n_evk        = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_lru[i] = w_valid[i] && (w_rank[i] == w_lru_rank);
            if (w_match[i]) begin
                w_found_rank = w_found_rank | w_rank[i];
                w_hit_value  = w_hit_value | w_value[i];
            end
        end
        n_hit   = |w_match;
        w_evict = w_is_put && !n_hit && (r_count >= r_cap);
        if (w_evict) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_lru[i]) begin
                    n_evk = n_evk | w_key[i];
                end
            end
        end
        n_ev    = w_evict;
        n_rdval = (n_hit && !w_is_put) ? w_hit_value : '0;
    end

    // Pick the lowest free entry, or the victim when at capacity
    assign w_free_oh = ~w_valid & (w_valid + ENTRIES'(1));
    assign w_sel     = w_evict ? w_lru : w_free_oh;

    assign w_ctl.fire = w_fire;
    assign w_ctl.hit  = n_hit;
    assign w_ctl.put  = w_is_put;

    // Occupancy after this operation
    always_comb begin
        n_count = r_count;
        if (w_fire && w_is_put && !n_hit && !w_evict) begin
            n_count = r_count + CntW'(1);
        end
        w_occ_ext = OccW'(n_count);
        n_occ     = w_occ_ext[OCC_BITS-1:0];
    end

    // Clamp a capacity write into one through ENTRIES
    always_comb begin
        n_cap = r_cap;
        if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                n_cap = CntW'(1);
            end else if (CmpW'(i_cfg_data) > CmpW'(ENTRIES)) begin
                n_cap = CntW'(ENTRIES);
            end else begin
                n_cap = CntW'(i_cfg_data);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CntW'(CapReset);
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap   <= n_cap;
            r_count <= n_count;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture a request word
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= t_func'(i_func);
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit   <= n_hit;
            r_rdval <= n_rdval;
            r_ev    <= n_ev;
            r_evk   <= n_evk;
            r_occ   <= n_occ;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_rdval;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evk;
    assign o_occupancy   = r_occ;

endmodule

`default_nettype wire

// File: src/lruc_entry.sv
// One cache entry: valid mark, key, value and recency rank, with its key compare.
`default_nettype none

module lruc_entry #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lruc_pkg::t_entry_ctl   i_ctl,
    input  logic                   i_sel,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic [RANK_BITS-1:0]   i_found_rank,
    output logic                   o_valid,
    output logic                   o_match,
    output logic [RANK_BITS-1:0]   o_rank,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [VALUE_BITS-1:0]  o_value
);
    import lruc_pkg::*;

    logic                  r_valid, n_valid;
    logic [RANK_BITS-1:0]  r_rank, n_rank;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;

    // Compare the stored key against the request
    assign o_match = r_valid && (r_key == i_key);
    assign o_valid = r_valid;
    assign o_rank  = r_rank;
    assign o_key   = r_key;
    assign o_value = r_value;

    // Work out the entry's next contents
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.fire) begin
            if (i_ctl.hit) begin
                if (o_match) begin
                    n_rank = '0;
                    if (i_ctl.put) begin
                        n_value = i_value;
                    end
                end else if (r_valid && (r_rank < i_found_rank)) begin
                    n_rank = r_rank + RANK_BITS'(1);
                end
            end else if (i_ctl.put) begin
                if (i_sel) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_value = i_value;
                    n_rank  = '0;
                end else if (r_valid) begin
                    n_rank = r_rank + RANK_BITS'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

`default_nettype wire
